>>> sv/ljsg_pkg.sv
// Types, constants, and joint sweep and saturation functions for the leg joint sweep generator.
// Depends on nothing; imported by leg_joint_sweep_generator and its testbench.
package ljsg_pkg;

   localparam int NUM_LEGS  = 6;
   localparam int LEG_W     = 3;
   localparam int ANGLE_W   = 13;
   localparam int MODE_W    = 3;

   localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = -13'sd4096;
   localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = 13'sd4095;

   // start pose: hip 0, thigh -30 deg, knee 120 deg
   localparam logic signed [ANGLE_W-1:0] START_HIP   = 13'sd0;
   localparam logic signed [ANGLE_W-1:0] START_THIGH = -13'sd600;
   localparam logic signed [ANGLE_W-1:0] START_KNEE  = 13'sd2400;

   localparam logic [MODE_W-1:0] MODE_KT_A  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_TH_A  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_ALL   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_KT_B  = 3'd4;
   localparam logic [MODE_W-1:0] MODE_TH_UP = 3'd5;
   localparam logic [MODE_W-1:0] MODE_TH_B  = 3'd6;

   typedef enum logic [1:0] {
      KIND_START   = 2'd0,
      KIND_ARMED   = 2'd1,
      KIND_STEPPED = 2'd2
   } tick_kind_type;

   // direction flags: bit0 hip, bit1 thigh, bit2 knee
   typedef struct packed {
      logic [2:0]                 rising;
      logic signed [ANGLE_W-1:0]  knee_raw;
      logic signed [ANGLE_W-1:0]  thigh;
      logic signed [ANGLE_W-1:0]  hip;
   } leg_state_type;

   typedef struct packed {
      logic                       flag;
      logic signed [ANGLE_W-1:0]  value;
   } joint_type;

   localparam logic signed [NUM_LEGS-1:0][ANGLE_W-1:0] HIP_RESET =
      {13'sd200, 13'sd100, 13'sd0, 13'sd200, 13'sd100, 13'sd0};
   localparam logic signed [NUM_LEGS-1:0][ANGLE_W-1:0] THIGH_RESET =
      {-13'sd800, -13'sd600, -13'sd600, -13'sd600, -13'sd800, -13'sd600};
   localparam logic signed [NUM_LEGS-1:0][ANGLE_W-1:0] KNEE_RESET =
      {13'sd1800, 13'sd1800, 13'sd1400, 13'sd1800, 13'sd1800, 13'sd2200};
   localparam logic [NUM_LEGS-1:0][MODE_W-1:0] MODE_RESET =
      {3'd6, 3'd5, 3'd4, 3'd6, 3'd5, 3'd1};

   function automatic logic signed [ANGLE_W-1:0] sat_angle(input logic signed [ANGLE_W:0] x);
      logic signed [ANGLE_W-1:0] r;
      if (x < $signed({ANGLE_MIN[ANGLE_W-1], ANGLE_MIN})) begin
         r = ANGLE_MIN;
      end else if (x > $signed({ANGLE_MAX[ANGLE_W-1], ANGLE_MAX})) begin
         r = ANGLE_MAX;
      end else begin
         r = x[ANGLE_W-1:0];
      end
      return r;
   endfunction

   // One step of a joint ramp. The flag flips instead of moving once past a limit.
   function automatic joint_type sweep_joint(
      input logic signed [ANGLE_W-1:0] v,
      input logic                      flag,
      input logic                      set_goes_up,
      input logic signed [ANGLE_W-1:0] up_lim,
      input logic                      up_strict,
      input logic signed [ANGLE_W-1:0] dn_lim,
      input logic [3:0]                step
   );
      joint_type                 r;
      logic                      going_up;
      logic                      in_range;
      logic signed [ANGLE_W:0]   wide;
      logic signed [ANGLE_W:0]   stp;
      going_up = flag ? set_goes_up : !set_goes_up;
      wide     = {v[ANGLE_W-1], v};
      stp      = $signed({{(ANGLE_W-3){1'b0}}, step});
      if (going_up) begin
         in_range = up_strict ? (v < up_lim) : (v <= up_lim);
      end else begin
         in_range = v > dn_lim;
      end
      r.value = v;
      r.flag  = flag;
      if (in_range) begin
         r.value = sat_angle(going_up ? wide + stp : wide - stp);
      end else begin
         r.flag = !flag;
      end
      return r;
   endfunction

endpackage

>>> sv/leg_joint_sweep_generator.sv
// Leg joint sweep generator: per-leg state held in a small synchronous RAM.
// Depends on ljsg_pkg (types, reset tables, sweep function).
//
// Usage:
//  req channel: one beat per gait tick, req_tdata[2:0] = leg index. A tick for
//  a leg index of 6 or 7 is taken and dropped with no response.
//  rsp channel: one beat per valid tick. tdata carries leg, hip, thigh and knee
//  angles (0.05 degree units); tuser carries the tick kind.
//  csr port: csr_we writes csr_wdata into the mode register of leg csr_addr.
//  Write modes only while no tick is in flight.
//  Pipeline: the state RAM read register, then the update and the output
//  register. Throughput: one tick per cycle while rsp_tready is high; a tick
//  for the leg updated in the previous cycle gets the result over a bypass
//  register, so back-to-back ticks to one leg do not stall.
//  Stall: when rsp_tready is low the output register holds; one more tick sits
//  in the update stage, then req_tready drops.
//  Reset: synchronous. Modes return to 1,5,6,4,5,6, every leg returns to
//  unstarted, and state RAM entries read as their reset pose until first
//  written (per-leg valid bits, no clearing pass).
module leg_joint_sweep_generator (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // [2:0] leg_index
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [47:0]                    rsp_tdata,   // [2:0] leg_out, [15:3] hip_angle,
                                                       // [28:16] thigh_angle, [41:29] knee_angle
   output logic [1:0]                     rsp_tuser,   // [1:0] tick_kind
   input  logic                           csr_we,
   input  logic [2:0]                     csr_addr,
   input  logic [2:0]                     csr_wdata
);
   import ljsg_pkg::*;

   logic [NUM_LEGS-1:0][MODE_W-1:0] mode_ff;
   logic [NUM_LEGS-1:0]             started_ff;
   logic [NUM_LEGS-1:0]             armed_ff;
   logic [NUM_LEGS-1:0]             written_ff;

   leg_state_type                   state_mem [NUM_LEGS];
   leg_state_type                   rd_data_ff;

   logic                            s1_valid_ff;
   logic [LEG_W-1:0]                s1_leg_ff;

   logic                            byp_valid_ff;
   logic [LEG_W-1:0]                byp_leg_ff;
   leg_state_type                   byp_data_ff;

   logic                            rsp_valid_ff;
   logic [LEG_W-1:0]                rsp_leg_ff;
   tick_kind_type                   rsp_kind_ff;
   logic signed [ANGLE_W-1:0]       rsp_hip_ff;
   logic signed [ANGLE_W-1:0]       rsp_thigh_ff;
   logic signed [ANGLE_W-1:0]       rsp_knee_ff;

   logic                            req_fire;
   logic                            req_leg_ok;
   logic [LEG_W-1:0]                req_leg;
   logic                            s1_go;
   logic [2:0]                      s1_idx;
   leg_state_type                   cur_state;
   leg_state_type                   new_state;
   tick_kind_type                   kind_in;
   logic signed [ANGLE_W-1:0]       hip_in;
   logic signed [ANGLE_W-1:0]       thigh_in;
   logic signed [ANGLE_W-1:0]       knee_in;
   logic                            wr_en;
   joint_type                       j_hip;
   joint_type                       j_thigh;
   joint_type                       j_knee;

   assign req_leg    = req_tdata[LEG_W-1:0];
   assign req_leg_ok = req_leg < LEG_W'(NUM_LEGS);
   assign s1_go      = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_go;
   assign req_fire   = req_tvalid && req_tready;
   assign s1_idx     = s1_leg_ff;

   // state RAM: one write port from the update stage, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         state_mem[s1_idx] <= new_state;
      end
      if (req_fire && req_leg_ok) begin
         rd_data_ff <= state_mem[req_leg];
      end
   end

   // pick freshest copy: last write, RAM, or reset pose
   always_comb begin
      if (byp_valid_ff && byp_leg_ff == s1_leg_ff) begin
         cur_state = byp_data_ff;
      end else if (written_ff[s1_idx]) begin
         cur_state = rd_data_ff;
      end else begin
         cur_state.rising   = 3'b111;
         cur_state.hip      = HIP_RESET[s1_idx];
         cur_state.thigh    = THIGH_RESET[s1_idx];
         cur_state.knee_raw = KNEE_RESET[s1_idx];
      end
   end

   always_comb begin
      new_state = cur_state;
      j_hip     = '0;
      j_thigh   = '0;
      j_knee    = '0;
      case (mode_ff[s1_idx])
         MODE_KT_A, MODE_KT_B: begin
            j_knee  = sweep_joint(cur_state.knee_raw, cur_state.rising[2], 1'b1,
                                  13'sd2200, 1'b0, 13'sd1400, 4'd8);
            j_thigh = sweep_joint(cur_state.thigh, cur_state.rising[1], 1'b0,
                                  -13'sd400, 1'b0, -13'sd800, 4'd4);
            new_state.knee_raw  = j_knee.value;
            new_state.rising[2] = j_knee.flag;
            new_state.thigh     = j_thigh.value;
            new_state.rising[1] = j_thigh.flag;
         end
         MODE_TH_A, MODE_TH_B: begin
            j_thigh = sweep_joint(cur_state.thigh, cur_state.rising[1], 1'b0,
                                  -13'sd400, 1'b0, -13'sd800, 4'd4);
            j_hip   = sweep_joint(cur_state.hip, cur_state.rising[0], 1'b0,
                                  13'sd200, 1'b1, -13'sd600, 4'd8);
            new_state.thigh     = j_thigh.value;
            new_state.rising[1] = j_thigh.flag;
            new_state.hip       = j_hip.value;
            new_state.rising[0] = j_hip.flag;
         end
         MODE_ALL: begin
            j_knee  = sweep_joint(cur_state.knee_raw, cur_state.rising[2], 1'b1,
                                  13'sd1800, 1'b0, 13'sd1400, 4'd6);
            j_thigh = sweep_joint(cur_state.thigh, cur_state.rising[1], 1'b0,
                                  -13'sd400, 1'b0, -13'sd600, 4'd2);
            j_hip   = sweep_joint(cur_state.hip, cur_state.rising[0], 1'b1,
                                  13'sd700, 1'b0, 13'sd0, 4'd7);
            new_state.knee_raw  = j_knee.value;
            new_state.rising[2] = j_knee.flag;
            new_state.thigh     = j_thigh.value;
            new_state.rising[1] = j_thigh.flag;
            new_state.hip       = j_hip.value;
            new_state.rising[0] = j_hip.flag;
         end
         MODE_TH_UP: begin
            j_thigh = sweep_joint(cur_state.thigh, cur_state.rising[1], 1'b0,
                                  -13'sd400, 1'b0, -13'sd800, 4'd4);
            j_hip   = sweep_joint(cur_state.hip, cur_state.rising[0], 1'b1,
                                  13'sd600, 1'b0, -13'sd200, 4'd8);
            new_state.thigh     = j_thigh.value;
            new_state.rising[1] = j_thigh.flag;
            new_state.hip       = j_hip.value;
            new_state.rising[0] = j_hip.flag;
         end
         default: begin
            new_state = cur_state;
         end
      endcase
   end

   always_comb begin
      wr_en = 1'b0;
      if (!started_ff[s1_idx]) begin
         kind_in  = KIND_START;
         hip_in   = START_HIP;
         thigh_in = START_THIGH;
         knee_in  = START_KNEE;
      end else if (!armed_ff[s1_idx]) begin
         kind_in  = KIND_ARMED;
         hip_in   = cur_state.hip;
         thigh_in = cur_state.thigh;
         knee_in  = sat_angle({cur_state.knee_raw[ANGLE_W-1], cur_state.knee_raw}
                              - {cur_state.thigh[ANGLE_W-1], cur_state.thigh});
      end else begin
         kind_in  = KIND_STEPPED;
         wr_en    = s1_go;
         hip_in   = new_state.hip;
         thigh_in = new_state.thigh;
         knee_in  = sat_angle({new_state.knee_raw[ANGLE_W-1], new_state.knee_raw}
                              - {new_state.thigh[ANGLE_W-1], new_state.thigh});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_RESET;
         started_ff   <= '0;
         armed_ff     <= '0;
         written_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         byp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we && csr_addr < LEG_W'(NUM_LEGS)) begin
            mode_ff[csr_addr] <= csr_wdata;
         end
         if (s1_go) begin
            started_ff[s1_idx] <= 1'b1;
            if (started_ff[s1_idx]) begin
               armed_ff[s1_idx] <= 1'b1;
            end
         end
         if (wr_en) begin
            written_ff[s1_idx] <= 1'b1;
            byp_valid_ff       <= 1'b1;
         end
         if (req_tready) begin
            s1_valid_ff <= req_fire && req_leg_ok;
         end
         if (s1_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_leg_ff <= req_leg;
      end
      if (wr_en) begin
         byp_leg_ff  <= s1_leg_ff;
         byp_data_ff <= new_state;
      end
      if (s1_go) begin
         rsp_leg_ff   <= s1_leg_ff;
         rsp_kind_ff  <= kind_in;
         rsp_hip_ff   <= hip_in;
         rsp_thigh_ff <= thigh_in;
         rsp_knee_ff  <= knee_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {6'b0, rsp_knee_ff, rsp_thigh_ff, rsp_hip_ff, rsp_leg_ff};

endmodule

>>> dv/tb_leg_joint_sweep_generator.sv
`timescale 1ns / 1ps
// Self-checking testbench for leg_joint_sweep_generator: directed tick table, then random
// ticks over several mode settings, checked against a cycle-free predictor of the legs.
// Depends on ljsg_pkg and the leg_joint_sweep_generator RTL.
module tb_leg_joint_sweep_generator;
   import ljsg_pkg::*;

   localparam logic [MODE_W-1:0] MODE_NONE_LO  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_NONE_HI  = 3'd7;
   localparam logic [2:0]        REG_MODE_BASE = 3'd0;
   localparam int NUM_PHASES      = 8;
   localparam int TABLE_PHASES    = 5;
   localparam int TICKS_PER_PHASE = 250;
   localparam int DRAIN_CYCLES    = 8;
   localparam int HOLD_AT_BEAT    = 300;
   localparam int HOLD_CYCLES     = 80;

   typedef struct packed {
      logic [LEG_W-1:0]          leg;
      tick_kind_type             kind;
      logic signed [ANGLE_W-1:0] hip;
      logic signed [ANGLE_W-1:0] thigh;
      logic signed [ANGLE_W-1:0] knee;
   } leg_pose_type;

   typedef struct packed {
      logic         typed;   // pose below is the expected response
      leg_pose_type pose;
   } tick_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_we;
   logic [2:0]  csr_addr;
   logic [2:0]  csr_wdata;

   leg_joint_sweep_generator DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // ---------------- leg model ----------------
   int               hip_init   [NUM_LEGS] = '{0, 100, 200, 0, 100, 200};
   int               thigh_init [NUM_LEGS] = '{-600, -800, -600, -600, -600, -800};
   int               knee_init  [NUM_LEGS] = '{2200, 1800, 1800, 1400, 1800, 1800};
   logic [MODE_W-1:0] mode_init [NUM_LEGS] =
      '{MODE_KT_A, MODE_TH_UP, MODE_TH_B, MODE_KT_B, MODE_TH_UP, MODE_TH_B};

   logic [MODE_W-1:0] leg_mode [NUM_LEGS];
   int  hip_pos   [NUM_LEGS];
   int  thigh_pos [NUM_LEGS];
   int  knee_raw  [NUM_LEGS];
   bit  hip_flag   [NUM_LEGS];
   bit  thigh_flag [NUM_LEGS];
   bit  knee_flag  [NUM_LEGS];
   bit  leg_started [NUM_LEGS];
   bit  leg_armed   [NUM_LEGS];

   leg_pose_type pending_poses [$];
   int           error_count = 0;

   function automatic void reset_legs();
      for (int i = 0; i < NUM_LEGS; i++) begin
         leg_mode[i]    = mode_init[i];
         hip_pos[i]     = hip_init[i];
         thigh_pos[i]   = thigh_init[i];
         knee_raw[i]    = knee_init[i];
         hip_flag[i]    = 1'b1;
         thigh_flag[i]  = 1'b1;
         knee_flag[i]   = 1'b1;
         leg_started[i] = 1'b0;
         leg_armed[i]   = 1'b0;
      end
   endfunction

   function automatic int clamp13(input int v);
      if (v < -4096) return -4096;
      if (v > 4095) return 4095;
      return v;
   endfunction

   // One ramp step. A set flag means "up" when set_up is true. Past the limit the
   // joint holds and its flag toggles instead.
   function automatic int ramp(input int v, inout bit flag, input bit set_up,
                               input int hi, input bit hi_strict, input int lo,
                               input int stp);
      bit up;
      bit go;
      up = flag ? set_up : !set_up;
      if (up) go = hi_strict ? (v < hi) : (v <= hi);
      else    go = v > lo;
      if (go) return clamp13(up ? v + stp : v - stp);
      flag = !flag;
      return v;
   endfunction

   function automatic void step_leg(input int i);
      case (leg_mode[i])
         MODE_KT_A, MODE_KT_B: begin
            knee_raw[i]  = ramp(knee_raw[i], knee_flag[i], 1'b1, 2200, 1'b0, 1400, 8);
            thigh_pos[i] = ramp(thigh_pos[i], thigh_flag[i], 1'b0, -400, 1'b0, -800, 4);
         end
         MODE_TH_A, MODE_TH_B: begin
            thigh_pos[i] = ramp(thigh_pos[i], thigh_flag[i], 1'b0, -400, 1'b0, -800, 4);
            // hip rises only while strictly below its upper limit here
            hip_pos[i]   = ramp(hip_pos[i], hip_flag[i], 1'b0, 200, 1'b1, -600, 8);
         end
         MODE_ALL: begin
            knee_raw[i]  = ramp(knee_raw[i], knee_flag[i], 1'b1, 1800, 1'b0, 1400, 6);
            thigh_pos[i] = ramp(thigh_pos[i], thigh_flag[i], 1'b0, -400, 1'b0, -600, 2);
            hip_pos[i]   = ramp(hip_pos[i], hip_flag[i], 1'b1, 700, 1'b0, 0, 7);
         end
         MODE_TH_UP: begin
            thigh_pos[i] = ramp(thigh_pos[i], thigh_flag[i], 1'b0, -400, 1'b0, -800, 4);
            hip_pos[i]   = ramp(hip_pos[i], hip_flag[i], 1'b1, 600, 1'b0, -200, 8);
         end
         default: ;   // undefined modes hold every joint
      endcase
   endfunction

   // Advances the model by one tick; returns 0 when the tick gives no response.
   function automatic bit predict_tick(input logic [LEG_W-1:0] leg, output leg_pose_type p);
      int i;
      p = '0;
      if (leg >= NUM_LEGS) return 1'b0;
      i = leg;
      p.leg = leg;
      if (!leg_started[i]) begin
         leg_started[i] = 1'b1;
         p.kind  = KIND_START;
         p.hip   = START_HIP;
         p.thigh = START_THIGH;
         p.knee  = START_KNEE;
         return 1'b1;
      end
      if (!leg_armed[i]) begin
         leg_armed[i] = 1'b1;
         p.kind = KIND_ARMED;
      end else begin
         step_leg(i);
         p.kind = KIND_STEPPED;
      end
      p.hip   = 13'(hip_pos[i]);
      p.thigh = 13'(thigh_pos[i]);
      p.knee  = 13'(clamp13(knee_raw[i] - thigh_pos[i]));
      return 1'b1;
   endfunction

   // ---------------- directed ticks ----------------
   // Reset modes 1,5,6,4,5,6: start pose, then armed ticks report the reset pose.
   tick_row_type directed_rows [24] = '{
      '{1'b1, '{3'd0, KIND_START, 0, -600, 2400}},
      '{1'b1, '{3'd0, KIND_ARMED, 0, -600, 2800}},
      '{1'b0, '{3'd6, KIND_START, 0, 0, 0}},
      '{1'b0, '{3'd7, KIND_START, 0, 0, 0}},
      '{1'b1, '{3'd1, KIND_START, 0, -600, 2400}},
      '{1'b1, '{3'd2, KIND_START, 0, -600, 2400}},
      '{1'b1, '{3'd3, KIND_START, 0, -600, 2400}},
      '{1'b1, '{3'd4, KIND_START, 0, -600, 2400}},
      '{1'b1, '{3'd5, KIND_START, 0, -600, 2400}},
      '{1'b1, '{3'd1, KIND_ARMED, 100, -800, 2600}},
      '{1'b1, '{3'd2, KIND_ARMED, 200, -600, 2400}},
      '{1'b1, '{3'd3, KIND_ARMED, 0, -600, 2000}},
      '{1'b1, '{3'd4, KIND_ARMED, 100, -600, 2400}},
      '{1'b1, '{3'd5, KIND_ARMED, 200, -800, 2600}},
      '{1'b0, '{3'd0, KIND_STEPPED, 0, 0, 0}},
      '{1'b0, '{3'd1, KIND_STEPPED, 0, 0, 0}},
      '{1'b0, '{3'd2, KIND_STEPPED, 0, 0, 0}},
      '{1'b0, '{3'd3, KIND_STEPPED, 0, 0, 0}},
      '{1'b0, '{3'd4, KIND_STEPPED, 0, 0, 0}},
      '{1'b0, '{3'd5, KIND_STEPPED, 0, 0, 0}},
      '{1'b0, '{3'd0, KIND_STEPPED, 0, 0, 0}},
      '{1'b0, '{3'd0, KIND_STEPPED, 0, 0, 0}},
      '{1'b0, '{3'd0, KIND_STEPPED, 0, 0, 0}},
      '{1'b0, '{3'd5, KIND_STEPPED, 0, 0, 0}}
   };

   logic [MODE_W-1:0] phase_modes [TABLE_PHASES][NUM_LEGS] = '{
      '{MODE_KT_A, MODE_TH_A, MODE_ALL, MODE_KT_B, MODE_TH_UP, MODE_TH_B},
      '{MODE_ALL, MODE_ALL, MODE_ALL, MODE_ALL, MODE_ALL, MODE_ALL},
      '{MODE_NONE_LO, MODE_NONE_HI, MODE_NONE_LO, MODE_NONE_HI, MODE_NONE_LO, MODE_NONE_HI},
      '{MODE_TH_B, MODE_TH_UP, MODE_KT_B, MODE_ALL, MODE_TH_A, MODE_KT_A},
      '{MODE_NONE_HI, MODE_ALL, MODE_NONE_LO, MODE_ALL, MODE_NONE_HI, MODE_TH_A}
   };

   // ---------------- clock and time limit ----------------
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // ---------------- request side ----------------
   task automatic send_tick(input logic [LEG_W-1:0] leg, input logic given,
                            input leg_pose_type given_pose);
      leg_pose_type p;
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, leg};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (predict_tick(leg, p))
         pending_poses.insert(pending_poses.size(), given ? given_pose : p);
   endtask

   // Stop offering and let every response (and any dropped tick) clear the pipe.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_poses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input logic [2:0] addr, input logic [MODE_W-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      @(posedge clock);
      if (addr < NUM_LEGS) leg_mode[addr] = value;
   endtask

   initial begin
      int          ticks;
      int          burst;
      int          gap;
      int          favorite;
      int          pick;
      logic [2:0]  leg;
      logic [2:0]  mode;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_addr   = '0;
      csr_wdata  = '0;
      reset      = 1'b1;
      reset_legs();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r])
         send_tick(directed_rows[r].pose.leg, directed_rows[r].typed, directed_rows[r].pose);

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         wait_idle();
         for (int k = 0; k < NUM_LEGS; k++) begin
            if (ph < TABLE_PHASES) mode = phase_modes[ph][k];
            else if ($urandom_range(0, 9) == 0) mode = $urandom_range(0, 1) ? MODE_NONE_HI
                                                                            : MODE_NONE_LO;
            else mode = 3'($urandom_range(1, 6));
            write_mode(REG_MODE_BASE + 3'(k), mode);
         end
         // addresses past the last leg must not disturb any leg
         if (ph == 0) begin
            write_mode(REG_MODE_BASE + 3'(NUM_LEGS), MODE_NONE_LO);
            write_mode(REG_MODE_BASE + 3'(NUM_LEGS + 1), MODE_NONE_HI);
         end
         csr_we <= 1'b0;

         favorite = $urandom_range(0, NUM_LEGS - 1);
         burst    = $urandom_range(1, 24);
         ticks    = 0;
         while (ticks < TICKS_PER_PHASE) begin
            pick = $urandom_range(0, 99);
            if (pick < 5)       leg = 3'($urandom_range(NUM_LEGS, 7));
            else if (pick < 50) leg = 3'(favorite);
            else                leg = 3'($urandom_range(0, NUM_LEGS - 1));
            send_tick(leg, 1'b0, '0);
            if (leg < NUM_LEGS) ticks++;
            burst--;
            if (burst == 0) begin
               gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               if (gap > 0) begin
                  req_tvalid <= 1'b0;
                  repeat (gap) @(posedge clock);
               end
               burst = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 120)
                                                   : $urandom_range(1, 24);
            end else if ($urandom_range(0, 299) == 0) begin
               wait_idle();
            end
         end
      end

      wait_idle();
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // ---------------- response side ----------------
   int rx_beats    = 0;
   int hold_left   = 0;
   bit held_once   = 1'b0;
   int rx_cycle    = 0;
   int stall_style = 0;

   task automatic check_field(input string name, input logic signed [12:0] want,
                              input logic signed [12:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   task automatic check_beat();
      leg_pose_type want;
      if (pending_poses.size() == 0) begin
         $error("response beat for leg %0d with no tick pending", rsp_tdata[2:0]);
         error_count++;
      end else begin
         want = pending_poses.pop_front();
         check_field("leg_out", 13'(want.leg), 13'(rsp_tdata[2:0]));
         check_field("tick_kind", 13'(want.kind), 13'(rsp_tuser));
         check_field("hip_angle", want.hip, rsp_tdata[15:3]);
         check_field("thigh_angle", want.thigh, rsp_tdata[28:16]);
         check_field("knee_angle", want.knee, rsp_tdata[41:29]);
      end
      rx_beats++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_beat();
      rx_cycle++;
      if (rx_cycle % 64 == 0) stall_style = $urandom_range(0, 3);
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (!held_once && rx_beats >= HOLD_AT_BEAT) begin
         // long back-pressure so the block fills and stalls its input
         held_once = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         case (stall_style)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= ($urandom_range(0, 99) < 60);
            2:       rsp_tready <= (rx_cycle % 3 == 0);
            default: rsp_tready <= (rx_cycle % 8 != 0);
         endcase
      end
   end

endmodule

>>> leg_joint_sweep_generator.f
sv/ljsg_pkg.sv
sv/leg_joint_sweep_generator.sv
dv/tb_leg_joint_sweep_generator.sv
